// ===== src/fre_pkg.sv =====
// Shared types, codes and helper functions of the fragment reassembly engine.
`default_nettype none
package fre_pkg;

  localparam int LEN_W = 11;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_BYTE = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [2:0] ST_NONE       = 3'd0;
  localparam logic [2:0] ST_INVALID    = 3'd1;
  localparam logic [2:0] ST_DUPLICATE  = 3'd2;
  localparam logic [2:0] ST_SUPERSEDED = 3'd3;
  localparam logic [2:0] ST_TIMEOUT    = 3'd4;
  localparam logic [2:0] ST_CRC_ERROR  = 3'd5;
  localparam logic [2:0] ST_COMPLETE   = 3'd6;
  localparam logic [2:0] ST_READ_BYTE  = 3'd7;

  localparam logic [7:0]  RTCM_PREAMBLE = 8'hD3;
  localparam logic [24:0] CRC24Q_POLY   = 25'h1864CFB;

  typedef struct packed {
    logic [1:0]       func;
    logic             header_bad;
    logic [15:0]      stream_id;
    logic [31:0]      frame_sequence;
    logic [LEN_W-1:0] frame_length;
    logic [3:0]       fragment_count;
    logic [2:0]       fragment_index;
    logic [6:0]       byte_pos;
    logic [7:0]       data_byte;
    logic             last_byte;
  } item_t;

  // Wrapping serial comparison: cand is ahead of ref by less than half the space.
  function automatic logic is_newer(input logic [31:0] cand, input logic [31:0] ref_seq);
    logic [31:0] d;
    d = cand - ref_seq;
    return (d != 32'd0) && !d[31];
  endfunction

  // One byte through CRC-24Q, MSB first.
  function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
    logic [24:0] c;
    c = {1'b0, crc ^ {b, 16'd0}};
    for (int k = 0; k < 8; k++) begin
      c = {c[23:0], 1'b0};
      if (c[24]) begin
        c = c ^ CRC24Q_POLY;
      end
    end
    return c[23:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/fragment_reassembly_engine.sv =====
// Top level of the fragment reassembly engine.
// A tick or payload byte result is registered from the queue head; a read result also passes
// the read state and the frame store's read register. The result strobe lasts one cycle.
// Throughput: one tick or payload byte per cycle while the back end is not stalled; a read
// holds the back end in its read state, and a frame completion holds it for the CRC scan
// over the single read port of the frame store, one byte a cycle.
// Reset clears all control state; the frame store is not cleared and needs no sweep.
`default_nettype none
module fragment_reassembly_engine #(
  parameter int MAX_FRAME_BYTES    = 1024,
  parameter int FRAG_PAYLOAD_BYTES = 128,
  parameter int MAX_FRAGMENTS      = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [31:0]               cfg_data_i,
  input  wire logic [1:0]                func_i,
  input  wire logic                      header_ok_i,
  input  wire logic [15:0]               stream_id_i,
  input  wire logic [31:0]               frame_sequence_i,
  input  wire logic [fre_pkg::LEN_W-1:0] frame_length_i,
  input  wire logic [3:0]                fragment_count_i,
  input  wire logic [2:0]                fragment_index_i,
  input  wire logic [6:0]                byte_pos_i,
  input  wire logic [7:0]                data_byte_i,
  input  wire logic                      last_byte_i,
  output logic                           done_o,
  output logic [2:0]                     status_o,
  output logic                           ack_valid_o,
  output logic [15:0]                    ack_stream_o,
  output logic [31:0]                    ack_sequence_o,
  output logic [30:0]                    gap_count_o,
  output logic [7:0]                     out_byte_o,
  output logic                           out_last_o
);

  // The timeout register accepts a write transaction in every cycle.
  logic [31:0]    timeout_q;
  logic           full, head_valid, pop;
  fre_pkg::item_t head;

  assign cfg_ready_o = 1'b1;
  // New transactions are refused only while the two-entry queue is full.
  assign busy        = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 32'd1000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_data_i;
    end
  end

  // The front end checks the header fields once and queues the transaction.
  fre_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .MAX_FRAGMENTS   (MAX_FRAGMENTS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (start && !busy),
    .func_i           (func_i),
    .header_ok_i      (header_ok_i),
    .stream_id_i      (stream_id_i),
    .frame_sequence_i (frame_sequence_i),
    .frame_length_i   (frame_length_i),
    .fragment_count_i (fragment_count_i),
    .fragment_index_i (fragment_index_i),
    .byte_pos_i       (byte_pos_i),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .full_o           (full),
    .head_valid_o     (head_valid),
    .head_o           (head),
    .pop_i            (pop)
  );

  // The back end owns the reassembly state and the frame store, and stalls the queue
  // during reads and CRC scans.
  fre_back #(
    .MAX_FRAME_BYTES    (MAX_FRAME_BYTES),
    .FRAG_PAYLOAD_BYTES (FRAG_PAYLOAD_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .timeout_i      (timeout_q),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .done_o         (done_o),
    .status_o       (status_o),
    .ack_valid_o    (ack_valid_o),
    .ack_stream_o   (ack_stream_o),
    .ack_sequence_o (ack_sequence_o),
    .gap_count_o    (gap_count_o),
    .out_byte_o     (out_byte_o),
    .out_last_o     (out_last_o)
  );

endmodule
`default_nettype wire

// ===== src/fre_front.sv =====
// Front end: takes transactions, classifies the header and queues them.
`default_nettype none
module fre_front #(
  parameter int MAX_FRAME_BYTES = 1024,
  parameter int MAX_FRAGMENTS   = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire logic [1:0]              func_i,
  input  wire logic                    header_ok_i,
  input  wire logic [15:0]             stream_id_i,
  input  wire logic [31:0]             frame_sequence_i,
  input  wire logic [fre_pkg::LEN_W-1:0] frame_length_i,
  input  wire logic [3:0]              fragment_count_i,
  input  wire logic [2:0]              fragment_index_i,
  input  wire logic [6:0]              byte_pos_i,
  input  wire logic [7:0]              data_byte_i,
  input  wire logic                    last_byte_i,
  output logic                         full_o,
  output logic                         head_valid_o,
  output fre_pkg::item_t               head_o,
  input  wire logic                    pop_i
);

  fre_pkg::item_t item;
  fre_pkg::item_t entry_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;

  always_comb begin
    item.func           = func_i;
    item.header_bad     = !header_ok_i || (fragment_count_i == 4'd0) ||
                          (32'(fragment_count_i) > MAX_FRAGMENTS) ||
                          ({1'b0, fragment_index_i} >= fragment_count_i) ||
                          (32'(frame_length_i) > MAX_FRAME_BYTES);
    item.stream_id      = stream_id_i;
    item.frame_sequence = frame_sequence_i;
    item.frame_length   = frame_length_i;
    item.fragment_count = fragment_count_i;
    item.fragment_index = fragment_index_i;
    item.byte_pos       = byte_pos_i;
    item.data_byte      = data_byte_i;
    item.last_byte      = last_byte_i;
  end

  assign full_o       = count_q == 2'd2;
  assign head_valid_o = count_q != 2'd0;
  assign head_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

// ===== src/fre_back.sv =====
// Back end: reassembly state, frame store, CRC check and read-out.
`default_nettype none
module fre_back #(
  parameter int MAX_FRAME_BYTES    = 1024,
  parameter int FRAG_PAYLOAD_BYTES = 128
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [31:0]    timeout_i,
  input  wire logic           head_valid_i,
  input  wire fre_pkg::item_t head_i,
  output logic                pop_o,
  output logic                done_o,
  output logic [2:0]          status_o,
  output logic                ack_valid_o,
  output logic [15:0]         ack_stream_o,
  output logic [31:0]         ack_sequence_o,
  output logic [30:0]         gap_count_o,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o
);

  localparam int AW   = $clog2(MAX_FRAME_BYTES);
  localparam int LW   = fre_pkg::LEN_W;
  localparam int OFFW = $clog2(8 * FRAG_PAYLOAD_BYTES + 128) + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  logic [1:0]  state_q, state_d;
  logic        asm_q, asm_d, pa_q, pa_d, have_done_q, have_done_d, ready_q, ready_d;
  logic [15:0] cur_stream_q, cur_stream_d, done_stream_q, done_stream_d;
  logic [31:0] cur_seq_q, cur_seq_d, done_seq_q, done_seq_d, age_q, age_d;
  logic [LW-1:0] cur_len_q, cur_len_d, ready_len_q, ready_len_d;
  logic [LW-1:0] rp_q, rp_d, cnt_q, cnt_d;
  logic [3:0]  cur_cnt_q, cur_cnt_d, total_q, total_d;
  logic [7:0]  bitmap_q, bitmap_d;
  logic [2:0]  cur_idx_q, cur_idx_d;
  logic [23:0] crc_q, crc_d, rx_q, rx_d;
  logic [7:0]  b1_q, b1_d, b2_q, b2_d;
  logic        b0_ok_q, b0_ok_d;

  logic        res_v_d, ackv_d, ol_d;
  logic [2:0]  st_d;
  logic [15:0] acks_d;
  logic [31:0] ackq_d;
  logic [30:0] gap_d;
  logic        ob_sel;

  // Remembers whether the read issued last cycle was the final byte.
  logic out_last_pend_q;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata_q;
  logic [7:0]    mem [MAX_FRAME_BYTES];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    logic        go;
    logic [OFFW-1:0] off;
    logic [31:0] exp_seq;
    logic [LW-1:0] idx;
    logic [23:0] rx_fin;
    logic        ok;

    state_d = state_q; asm_d = asm_q; pa_d = pa_q; have_done_d = have_done_q;
    ready_d = ready_q; cur_stream_d = cur_stream_q; done_stream_d = done_stream_q;
    cur_seq_d = cur_seq_q; done_seq_d = done_seq_q; age_d = age_q;
    cur_len_d = cur_len_q; ready_len_d = ready_len_q; rp_d = rp_q; cnt_d = cnt_q;
    cur_cnt_d = cur_cnt_q; total_d = total_q; bitmap_d = bitmap_q; cur_idx_d = cur_idx_q;
    crc_d = crc_q; rx_d = rx_q; b1_d = b1_q; b2_d = b2_q; b0_ok_d = b0_ok_q;
    res_v_d = 1'b0; st_d = fre_pkg::ST_NONE; ackv_d = 1'b0; acks_d = 16'd0;
    ackq_d = 32'd0; gap_d = 31'd0; ol_d = 1'b0; ob_sel = 1'b0;
    we = 1'b0; re = 1'b0; waddr = '0; raddr = '0; wdata = head_i.data_byte;
    pop_o = 1'b0; go = 1'b1; off = '0; exp_seq = '0; idx = '0; rx_fin = '0; ok = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          pop_o   = 1'b1;
          res_v_d = 1'b1;
          case (head_i.func)
            fre_pkg::FUNC_TICK: begin
              if (asm_q) begin
                if (age_q != 32'hFFFF_FFFF) begin
                  age_d = age_q + 32'd1;
                end
                if (age_d > timeout_i) begin
                  asm_d = 1'b0; bitmap_d = '0; total_d = '0; pa_d = 1'b0;
                  st_d = fre_pkg::ST_TIMEOUT;
                end
              end
            end
            fre_pkg::FUNC_READ: begin
              if (ready_q) begin
                re      = 1'b1;
                raddr   = AW'(rp_q);
                res_v_d = 1'b0;
                state_d = S_READ;
                if (LW'(rp_q + 1'b1) >= ready_len_q) begin
                  ol_d = 1'b1; ready_d = 1'b0; rp_d = '0;
                end else begin
                  rp_d = rp_q + 1'b1;
                end
              end
            end
            fre_pkg::FUNC_BYTE: begin
              if (head_i.byte_pos == 7'd0) begin
                pa_d = 1'b0;
                if (head_i.header_bad) begin
                  st_d = fre_pkg::ST_INVALID; go = 1'b0;
                end else if (have_done_q && head_i.stream_id == done_stream_q &&
                             !fre_pkg::is_newer(head_i.frame_sequence, done_seq_q)) begin
                  st_d = fre_pkg::ST_DUPLICATE; go = 1'b0;
                  if (head_i.frame_sequence == done_seq_q && head_i.fragment_index == 3'd0) begin
                    ackv_d = 1'b1; acks_d = head_i.stream_id; ackq_d = head_i.frame_sequence;
                  end
                end
                if (go) begin
                  if (asm_q && head_i.stream_id == cur_stream_q &&
                      head_i.frame_sequence != cur_seq_q &&
                      !fre_pkg::is_newer(head_i.frame_sequence, cur_seq_q)) begin
                    st_d = fre_pkg::ST_DUPLICATE; go = 1'b0;
                  end else if (!asm_q || head_i.stream_id != cur_stream_q ||
                               head_i.frame_sequence != cur_seq_q) begin
                    if (asm_q) begin
                      st_d = fre_pkg::ST_SUPERSEDED;
                    end
                    asm_d = 1'b1; bitmap_d = '0; total_d = '0; pa_d = 1'b0;
                    cur_stream_d = head_i.stream_id; cur_seq_d = head_i.frame_sequence;
                    cur_len_d = head_i.frame_length; cur_cnt_d = head_i.fragment_count;
                    age_d = '0;
                  end
                end
                if (go && (head_i.frame_length != cur_len_d ||
                           head_i.fragment_count != cur_cnt_d)) begin
                  st_d = fre_pkg::ST_INVALID; go = 1'b0;
                  asm_d = 1'b0; bitmap_d = '0; total_d = '0; pa_d = 1'b0;
                end
                if (go && bitmap_d[head_i.fragment_index]) begin
                  st_d = fre_pkg::ST_DUPLICATE; go = 1'b0;
                  if (head_i.fragment_index == 3'd0) begin
                    age_d = '0;
                  end
                end
                if (go) begin
                  pa_d = 1'b1; cur_idx_d = head_i.fragment_index;
                end
              end
              if (pa_d && asm_d) begin
                off = OFFW'(cur_idx_d) * OFFW'(FRAG_PAYLOAD_BYTES) + OFFW'(head_i.byte_pos);
                if (32'(head_i.byte_pos) < FRAG_PAYLOAD_BYTES &&
                    32'(off) < MAX_FRAME_BYTES) begin
                  we = 1'b1; waddr = AW'(off);
                end
                if (head_i.last_byte) begin
                  pa_d = 1'b0;
                  bitmap_d = bitmap_d | (8'd1 << cur_idx_d);
                  total_d = total_d + 4'd1;
                  if (total_d == cur_cnt_d) begin
                    asm_d = 1'b0; bitmap_d = '0; total_d = '0;
                    if (cur_len_d < LW'(6)) begin
                      st_d = fre_pkg::ST_CRC_ERROR;
                    end else begin
                      res_v_d = 1'b0; state_d = S_CHECK; cnt_d = '0; crc_d = '0;
                    end
                  end
                end
              end else if (head_i.last_byte) begin
                pa_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        res_v_d = 1'b1; st_d = fre_pkg::ST_READ_BYTE; ob_sel = 1'b1;
        ol_d = !ready_q && rp_q == '0 && out_last_pend_q;
        state_d = S_IDLE;
      end
      S_CHECK: begin
        re = 1'b1; raddr = AW'(cnt_q); cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0) begin
          idx = cnt_q - 1'b1;
          if (idx == LW'(0)) b0_ok_d = rdata_q == fre_pkg::RTCM_PREAMBLE;
          if (idx == LW'(1)) b1_d = rdata_q;
          if (idx == LW'(2)) b2_d = rdata_q;
          if (idx < cur_len_q - LW'(3)) begin
            crc_d = fre_pkg::crc24q_byte(crc_q, rdata_q);
          end else begin
            rx_d = {rx_q[15:0], rdata_q};
          end
          if (cnt_q == cur_len_q) begin
            re = 1'b0; state_d = S_IDLE; res_v_d = 1'b1;
            rx_fin = {rx_q[15:0], rdata_q};
            ok = b0_ok_q && (LW'({b1_q[1:0], b2_q}) + LW'(6) == cur_len_q) &&
                 (crc_q == rx_fin);
            if (!ok) begin
              st_d = fre_pkg::ST_CRC_ERROR;
            end else begin
              if (have_done_q && cur_stream_q == done_stream_q) begin
                exp_seq = done_seq_q + 32'd1;
                if (cur_seq_q != exp_seq && fre_pkg::is_newer(cur_seq_q, exp_seq)) begin
                  gap_d = 31'(cur_seq_q - exp_seq);
                end
              end
              have_done_d = 1'b1; done_stream_d = cur_stream_q; done_seq_d = cur_seq_q;
              st_d = fre_pkg::ST_COMPLETE;
              ackv_d = 1'b1; acks_d = cur_stream_q; ackq_d = cur_seq_q;
              ready_d = 1'b1; rp_d = '0; ready_len_d = cur_len_q;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; asm_q <= 1'b0; pa_q <= 1'b0; have_done_q <= 1'b0;
      ready_q <= 1'b0; cur_stream_q <= '0; done_stream_q <= '0; cur_seq_q <= '0;
      done_seq_q <= '0; age_q <= '0; cur_len_q <= '0; ready_len_q <= '0; rp_q <= '0;
      cnt_q <= '0; cur_cnt_q <= '0; total_q <= '0; bitmap_q <= '0; cur_idx_q <= '0;
      crc_q <= '0; rx_q <= '0; b1_q <= '0; b2_q <= '0; b0_ok_q <= 1'b0;
      out_last_pend_q <= 1'b0;
      done_o <= 1'b0; status_o <= '0; ack_valid_o <= 1'b0; ack_stream_o <= '0;
      ack_sequence_o <= '0; gap_count_o <= '0; out_byte_o <= '0; out_last_o <= 1'b0;
    end else begin
      state_q <= state_d; asm_q <= asm_d; pa_q <= pa_d; have_done_q <= have_done_d;
      ready_q <= ready_d; cur_stream_q <= cur_stream_d; done_stream_q <= done_stream_d;
      cur_seq_q <= cur_seq_d; done_seq_q <= done_seq_d; age_q <= age_d;
      cur_len_q <= cur_len_d; ready_len_q <= ready_len_d; rp_q <= rp_d; cnt_q <= cnt_d;
      cur_cnt_q <= cur_cnt_d; total_q <= total_d; bitmap_q <= bitmap_d;
      cur_idx_q <= cur_idx_d; crc_q <= crc_d; rx_q <= rx_d; b1_q <= b1_d; b2_q <= b2_d;
      b0_ok_q <= b0_ok_d;
      if (state_q == S_IDLE) begin
        out_last_pend_q <= ol_d;
      end
      done_o         <= res_v_d;
      status_o       <= st_d;
      ack_valid_o    <= ackv_d;
      ack_stream_o   <= acks_d;
      ack_sequence_o <= ackq_d;
      gap_count_o    <= gap_d;
      out_byte_o     <= ob_sel ? rdata_q : 8'd0;
      out_last_o     <= ob_sel ? out_last_pend_q : 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== src/fre_checker.sv =====
// Port-level checker of the fragment reassembly engine and its bind.
`default_nettype none
module fre_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        done_o,
  input wire logic [2:0]  status_o,
  input wire logic        ack_valid_o,
  input wire logic [30:0] gap_count_o,
  input wire logic        out_last_o
);

  a_complete_acks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == fre_pkg::ST_COMPLETE |-> ack_valid_o) else $error("no ack");
  a_gap_only_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != fre_pkg::ST_COMPLETE |-> gap_count_o == 31'd0)
    else $error("stray gap");
  a_last_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_last_o |-> status_o == fre_pkg::ST_READ_BYTE) else $error("stray last");
  a_read_no_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == fre_pkg::ST_READ_BYTE |-> !ack_valid_o) else $error("read ack");

endmodule

bind fragment_reassembly_engine fre_port_checker u_fre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .done_o      (done_o),
  .status_o    (status_o),
  .ack_valid_o (ack_valid_o),
  .gap_count_o (gap_count_o),
  .out_last_o  (out_last_o)
);
`default_nettype wire

// ===== bench/fre_checker.sv =====
// Checker for the fragment reassembly engine: predicts each result and compares it.
module fre_checker
  import fre_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [31:0]      cfg_data_i,
  input  logic [1:0]       func_i,
  input  logic             header_ok_i,
  input  logic [15:0]      stream_id_i,
  input  logic [31:0]      frame_sequence_i,
  input  logic [LEN_W-1:0] frame_length_i,
  input  logic [3:0]       fragment_count_i,
  input  logic [2:0]       fragment_index_i,
  input  logic [6:0]       byte_pos_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  input  logic             done_i,
  input  logic [2:0]       status_i,
  input  logic             ack_valid_i,
  input  logic [15:0]      ack_stream_i,
  input  logic [31:0]      ack_sequence_i,
  input  logic [30:0]      gap_count_i,
  input  logic [7:0]       out_byte_i,
  input  logic             out_last_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [2:0]  status;
    logic        ack_valid;
    logic [15:0] ack_stream;
    logic [31:0] ack_sequence;
    logic [30:0] gap_count;
    logic [7:0]  out_byte;
    logic        out_last;
  } outcome_t;

  outcome_t expected_q[$];

  logic [31:0]      timeout_ticks;
  logic             assembling;
  logic [15:0]      cur_stream;
  logic [31:0]      cur_sequence;
  logic [LEN_W-1:0] cur_length;
  logic [3:0]       cur_count;
  logic [7:0]       seen_bitmap;
  logic [3:0]       seen_total;
  logic [31:0]      age_ticks;
  logic [2:0]       cur_index;
  logic             packet_open;
  logic [7:0]       frame_store [0:1023];
  logic             have_done;
  logic [15:0]      done_stream;
  logic [31:0]      done_sequence;
  logic [LEN_W-1:0] read_ptr;
  logic [LEN_W-1:0] ready_length;
  logic             frame_ready;

  function automatic logic seq_ahead(input logic [31:0] cand, input logic [31:0] base);
    logic [31:0] d;
    d = cand - base;
    return (d != 32'd0) && (d < 32'h8000_0000);
  endfunction

  function automatic void abandon_frame();
    assembling  = 1'b0;
    seen_bitmap = '0;
    seen_total  = '0;
    packet_open = 1'b0;
  endfunction

  function automatic void open_frame(input logic [15:0] s, input logic [31:0] q,
                                     input logic [LEN_W-1:0] len, input logic [3:0] cnt);
    abandon_frame();
    assembling   = 1'b1;
    cur_stream   = s;
    cur_sequence = q;
    cur_length   = len;
    cur_count    = cnt;
    age_ticks    = '0;
  endfunction

  // RTCM3 framing: preamble, ten-bit payload length plus six, CRC-24Q trailer.
  function automatic logic rtcm_frame_good(input logic [LEN_W-1:0] len);
    logic [24:0] c;
    logic [9:0]  plen;
    if (len < 6 || len > 1024 || frame_store[0] != RTCM_PREAMBLE) return 1'b0;
    plen = {frame_store[1][1:0], frame_store[2]};
    if ({1'b0, plen} + 11'd6 != len) return 1'b0;
    c = '0;
    for (int i = 0; i < int'(len) - 3; i++) begin
      c[23:16] = c[23:16] ^ frame_store[i];
      for (int k = 0; k < 8; k++) begin
        c = {c[23:0], 1'b0};
        if (c[24]) c = c ^ CRC24Q_POLY;
      end
    end
    return c[23:0] == {frame_store[len-3], frame_store[len-2], frame_store[len-1]};
  endfunction

  function automatic outcome_t predict_result(
    input logic [1:0] fn, input logic hok, input logic [15:0] sid, input logic [31:0] seq,
    input logic [LEN_W-1:0] flen, input logic [3:0] fcnt, input logic [2:0] fidx,
    input logic [6:0] pos, input logic [7:0] dat, input logic lst);
    outcome_t r;
    logic     go;
    logic [31:0] next_seq;
    r  = '0;
    go = 1'b1;
    if (fn == FUNC_TICK) begin
      if (assembling) begin
        if (age_ticks != 32'hFFFF_FFFF) age_ticks = age_ticks + 1;
        if (age_ticks > timeout_ticks) begin
          abandon_frame();
          r.status = ST_TIMEOUT;
        end
      end
    end else if (fn == FUNC_READ) begin
      if (frame_ready) begin
        r.out_byte = frame_store[read_ptr[9:0]];
        r.status   = ST_READ_BYTE;
        if ({1'b0, read_ptr} + 12'd1 >= {1'b0, ready_length}) begin
          r.out_last  = 1'b1;
          frame_ready = 1'b0;
          read_ptr    = '0;
        end else begin
          read_ptr = read_ptr + 1;
        end
      end
    end else if (fn == FUNC_BYTE) begin
      if (pos == 0) begin
        packet_open = 1'b0;
        if (!hok || fcnt == 0 || fcnt > 8 || {1'b0, fidx} >= fcnt || flen > 1024) begin
          r.status = ST_INVALID;
          go = 1'b0;
        end else if (have_done && sid == done_stream && !seq_ahead(seq, done_sequence)) begin
          // Late copy of the delivered or an older frame: acknowledge again on its first fragment.
          r.status = ST_DUPLICATE;
          if (seq == done_sequence && fidx == 0) begin
            r.ack_valid    = 1'b1;
            r.ack_stream   = sid;
            r.ack_sequence = seq;
          end
          go = 1'b0;
        end
        if (go) begin
          if (!assembling) begin
            open_frame(sid, seq, flen, fcnt);
          end else if (sid != cur_stream) begin
            r.status = ST_SUPERSEDED;
            open_frame(sid, seq, flen, fcnt);
          end else if (seq != cur_sequence) begin
            if (!seq_ahead(seq, cur_sequence)) begin
              r.status = ST_DUPLICATE;
              go = 1'b0;
            end else begin
              r.status = ST_SUPERSEDED;
              open_frame(sid, seq, flen, fcnt);
            end
          end
        end
        if (go && (flen != cur_length || fcnt != cur_count)) begin
          r.status = ST_INVALID;
          abandon_frame();
          go = 1'b0;
        end
        if (go && seen_bitmap[fidx]) begin
          r.status = ST_DUPLICATE;
          if (fidx == 0) age_ticks = '0;
          go = 1'b0;
        end
        if (go) begin
          packet_open = 1'b1;
          cur_index   = fidx;
        end
      end
      if (packet_open && assembling) begin
        frame_store[{cur_index, pos}] = dat;
        if (lst) begin
          packet_open = 1'b0;
          seen_bitmap[cur_index] = 1'b1;
          seen_total = seen_total + 1;
          if (seen_total == cur_count) begin
            if (!rtcm_frame_good(cur_length)) begin
              r.status = ST_CRC_ERROR;
            end else begin
              if (have_done && cur_stream == done_stream) begin
                next_seq = done_sequence + 1;
                if (cur_sequence != next_seq && seq_ahead(cur_sequence, next_seq))
                  r.gap_count = 31'(cur_sequence - next_seq);
              end
              have_done      = 1'b1;
              done_stream    = cur_stream;
              done_sequence  = cur_sequence;
              r.status       = ST_COMPLETE;
              r.ack_valid    = 1'b1;
              r.ack_stream   = cur_stream;
              r.ack_sequence = cur_sequence;
              frame_ready    = 1'b1;
              read_ptr       = '0;
              ready_length   = cur_length;
            end
            abandon_frame();
          end
        end
      end else if (lst) begin
        packet_open = 1'b0;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    outcome_t got;
    if (!rst_ni) begin
      expected_q.delete();
      fail_count_o  = 0;
      timeout_ticks = 32'd1000;
      abandon_frame();
      cur_stream    = '0;
      cur_sequence  = '0;
      cur_length    = '0;
      cur_count     = '0;
      age_ticks     = '0;
      cur_index     = '0;
      have_done     = 1'b0;
      done_stream   = '0;
      done_sequence = '0;
      read_ptr      = '0;
      ready_length  = '0;
      frame_ready   = 1'b0;
    end else begin
      // A result strobed now always belongs to an earlier transaction, so check first.
      if (done_i) begin
        got = '{status_i, ack_valid_i, ack_stream_i, ack_sequence_i,
                gap_count_i, out_byte_i, out_last_i};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, got);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) timeout_ticks = cfg_data_i;
      if (start_i && !busy_i)
        expected_q.push_back(predict_result(func_i, header_ok_i, stream_id_i,
          frame_sequence_i, frame_length_i, fragment_count_i, fragment_index_i,
          byte_pos_i, data_byte_i, last_byte_i));
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== bench/tb_fragment_reassembly_engine.sv =====
// Testbench top for the fragment reassembly engine: stimulus, clock, reset and verdict.
module tb_fragment_reassembly_engine;
  import fre_pkg::*;

  // How a generated frame is sent: intact, with a corrupted byte, abandoned part
  // way through, or with one fragment whose header disagrees on the frame length.
  typedef enum int {FRAME_GOOD, FRAME_BAD_CRC, FRAME_ABANDON, FRAME_MISMATCH} frame_kind_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [31:0]      cfg_data_i = '0;
  logic [1:0]       func_i = '0;
  logic             header_ok_i = 1'b0;
  logic [15:0]      stream_id_i = '0;
  logic [31:0]      frame_sequence_i = '0;
  logic [LEN_W-1:0] frame_length_i = '0;
  logic [3:0]       fragment_count_i = '0;
  logic [2:0]       fragment_index_i = '0;
  logic [6:0]       byte_pos_i = '0;
  logic [7:0]       data_byte_i = '0;
  logic             last_byte_i = 1'b0;
  logic             done_o;
  logic [2:0]       status_o;
  logic             ack_valid_o;
  logic [15:0]      ack_stream_o;
  logic [31:0]      ack_sequence_o;
  logic [30:0]      gap_count_o;
  logic [7:0]       out_byte_o;
  logic             out_last_o;
  int               fail_count;
  int               pending;

  int               idle_pct;
  int               tick_pct;
  int               sent_items;
  int               big_frames;
  logic [7:0]       frame_buf [0:1023];
  logic [15:0]      stream_ids [4];
  logic [31:0]      next_seq [4];

  always #5 clk_i = ~clk_i;

  fragment_reassembly_engine i_dut (
    .clk_i, .rst_ni, .start, .busy, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .func_i, .header_ok_i, .stream_id_i, .frame_sequence_i, .frame_length_i,
    .fragment_count_i, .fragment_index_i, .byte_pos_i, .data_byte_i, .last_byte_i,
    .done_o, .status_o, .ack_valid_o, .ack_stream_o, .ack_sequence_o, .gap_count_o,
    .out_byte_o, .out_last_o
  );

  fre_checker u_checker (
    .clk_i, .rst_ni,
    .start_i(start), .busy_i(busy), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .func_i, .header_ok_i, .stream_id_i, .frame_sequence_i, .frame_length_i,
    .fragment_count_i, .fragment_index_i, .byte_pos_i, .data_byte_i, .last_byte_i,
    .done_i(done_o), .status_i(status_o), .ack_valid_i(ack_valid_o),
    .ack_stream_i(ack_stream_o), .ack_sequence_i(ack_sequence_o),
    .gap_count_i(gap_count_o), .out_byte_i(out_byte_o), .out_last_i(out_last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Presents one transaction from the falling edge and holds it until the block
  // takes it. Before it the sender may idle, dropping start.
  task automatic drive(input logic [1:0] fn, input logic hok, input logic [15:0] sid,
                       input logic [31:0] seq, input logic [LEN_W-1:0] flen,
                       input logic [3:0] fcnt, input logic [2:0] fidx, input logic [6:0] pos,
                       input logic [7:0] dat, input logic lst);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    func_i           = fn;
    header_ok_i      = hok;
    stream_id_i      = sid;
    frame_sequence_i = seq;
    frame_length_i   = flen;
    fragment_count_i = fcnt;
    fragment_index_i = fidx;
    byte_pos_i       = pos;
    data_byte_i      = dat;
    last_byte_i      = lst;
    start            = 1'b1;
    do @(posedge clk_i); while (busy);
    sent_items++;
  endtask

  // Ticks and reads carry random header fields, which the block must ignore.
  task automatic drive_plain(input logic [1:0] fn);
    drive(fn, 1'($urandom), 16'($urandom), $urandom, 11'($urandom), 4'($urandom),
          3'($urandom), 7'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic maybe_tick();
    if ($urandom_range(99) < tick_pct) drive_plain(FUNC_TICK);
  endtask

  // Noise never sets last_byte, so it can never close a fragment whose bytes were
  // not all written; whatever it opens is abandoned by the next real packet.
  task automatic drive_noise();
    drive(2'($urandom), 1'($urandom), 16'($urandom), $urandom, 11'($urandom),
          4'($urandom), 3'($urandom), 7'($urandom), 8'($urandom), 1'b0);
  endtask

  task automatic drive_packet(input logic [15:0] sid, input logic [31:0] seq,
                              input logic [LEN_W-1:0] flen, input logic [3:0] fcnt,
                              input int idx, input int nbytes, input logic closes);
    for (int b = 0; b < nbytes; b++)
      drive(FUNC_BYTE, 1'b1, sid, seq, flen, fcnt, 3'(idx), 7'(b), frame_buf[idx * 128 + b],
            closes && (b == nbytes - 1));
  endtask

  // Fills the frame buffer with a valid RTCM3 frame of len bytes where len allows it.
  task automatic build_frame(input int len);
    logic [23:0] crc;
    logic [9:0]  plen;
    plen = 10'(len - 6);
    for (int i = 0; i < 1024; i++) frame_buf[i] = 8'($urandom);
    frame_buf[0] = RTCM_PREAMBLE;
    frame_buf[1] = {frame_buf[1][7:2], plen[9:8]};
    frame_buf[2] = plen[7:0];
    if (len >= 6) begin
      crc = '0;
      for (int i = 0; i < len - 3; i++) begin
        crc[23:16] = crc[23:16] ^ frame_buf[i];
        for (int k = 0; k < 8; k++)
          crc = crc[23] ? ({crc[22:0], 1'b0} ^ 24'h864CFB) : {crc[22:0], 1'b0};
      end
      {frame_buf[len-3], frame_buf[len-2], frame_buf[len-1]} = crc;
    end
  endtask

  // Sends a frame's fragments in random order, all of them unless abandoned. Each accepted
  // fragment carries all its bytes, so a completed frame never covers unwritten store bytes.
  task automatic send_frame(input logic [15:0] sid, input logic [31:0] seq, input int len,
                            input int cnt, input frame_kind_e kind);
    int order [8];
    int n_send;
    int idx;
    int nb;
    int t;
    logic [LEN_W-1:0] hdr_len;
    build_frame(len);
    if (kind == FRAME_BAD_CRC) begin
      t = $urandom_range(0, (len > 0 ? len : 1) - 1);
      frame_buf[t] = frame_buf[t] ^ (8'd1 << $urandom_range(0, 7));
    end
    for (int i = 0; i < cnt; i++) order[i] = i;
    for (int i = cnt - 1; i > 0; i--) begin
      t = $urandom_range(0, i);
      {order[i], order[t]} = {order[t], order[i]};
    end
    n_send = (kind == FRAME_ABANDON) ? $urandom_range(0, cnt - 1) : cnt;
    for (int j = 0; j < n_send; j++) begin
      idx = order[j];
      nb  = len - idx * 128;
      nb  = nb < 1 ? 1 : (nb > 128 ? 128 : nb);
      hdr_len = 11'(len);
      if (kind == FRAME_MISMATCH && cnt > 1 && j == n_send - 1) hdr_len = hdr_len ^ 11'd1;
      // An interrupted packet: a new start of packet must discard the part received.
      if (nb > 1 && $urandom_range(19) == 0)
        drive_packet(sid, seq, hdr_len, 4'(cnt), idx, $urandom_range(1, nb - 1), 1'b0);
      drive_packet(sid, seq, hdr_len, 4'(cnt), idx, nb, 1'b1);
      maybe_tick();
    end
    if (n_send > 0 && $urandom_range(9) == 0) begin
      idx = order[$urandom_range(0, n_send - 1)];
      nb  = len - idx * 128;
      nb  = nb < 1 ? 1 : (nb > 128 ? 128 : nb);
      drive_packet(sid, seq, 11'(len), 4'(cnt), idx, nb, 1'b1);
    end
  endtask

  task automatic read_out(input int n);
    repeat (n) drive_plain(FUNC_READ);
  endtask

  // The register is only written once every expected result has come back and
  // the back end has had time to finish any frame check still running.
  task automatic write_timeout(input logic [31:0] value);
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_traffic(input int n_items);
    int s;
    int r;
    int len;
    int cnt;
    int min_cnt;
    logic [31:0] seq;
    frame_kind_e kind;
    n_items = sent_items + n_items;
    while (sent_items < n_items) begin
      if ($urandom_range(99) < 8) repeat ($urandom_range(1, 4)) drive_noise();
      s = $urandom_range(0, 3);
      if (s == 3) stream_ids[3] = 16'($urandom);
      r = $urandom_range(99);
      if (r < 75)      seq = next_seq[s];
      else if (r < 88) seq = next_seq[s] + $urandom_range(1, 6);
      else if (r < 93) seq = next_seq[s] + $urandom;
      else             seq = next_seq[s] - $urandom_range(1, 4);
      if (seq - next_seq[s] < 32'h8000_0000) next_seq[s] = seq + 1;
      r = $urandom_range(99);
      if (r < 5)                         len = $urandom_range(0, 5);
      else if (r < 92)                   len = $urandom_range(6, 60);
      else if (r < 98 || big_frames > 2) len = $urandom_range(61, 300);
      else begin
        len = ($urandom_range(1) == 0) ? 1024 : $urandom_range(301, 1024);
        big_frames++;
      end
      min_cnt = (len + 127) / 128;
      if (min_cnt < 1) min_cnt = 1;
      cnt = $urandom_range(min_cnt, 8);
      r = $urandom_range(99);
      kind = r < 72 ? FRAME_GOOD : r < 82 ? FRAME_BAD_CRC : r < 92 ? FRAME_ABANDON
                                                                   : FRAME_MISMATCH;
      send_frame(stream_ids[s], seq, len, cnt, kind);
      if ($urandom_range(9) < 8) read_out(len + $urandom_range(0, 2));
      else                       read_out($urandom_range(0, 3));
    end
  endtask

  initial begin
    #10_000_000;
    $display("tb_fragment_reassembly_engine: FAIL");
    $finish;
  end

  initial begin
    sent_items = 0;
    big_frames = 0;
    idle_pct   = 35;
    tick_pct   = 5;
    stream_ids = '{16'h0000, 16'h0001, 16'hFFFF, 16'h5A5A};
    next_seq   = '{32'hFFFF_FFF8, 32'd0, 32'h7FFF_FFFE, 32'd100};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, with a short timeout so that one frame expires quickly.
    write_timeout(32'd2);
    drive_plain(FUNC_TICK);
    drive_plain(2'd3);
    drive_plain(FUNC_READ);
    // Bad headers: upstream rejection, zero and too many fragments, index out of
    // range, frame longer than the store.
    drive(FUNC_BYTE, 1'b0, 16'hABCD, 32'd1, 11'd8, 4'd1, 3'd0, 7'd0, 8'hFF, 1'b1);
    drive(FUNC_BYTE, 1'b1, 16'hABCD, 32'd1, 11'd8, 4'd0, 3'd0, 7'd0, 8'h00, 1'b1);
    drive(FUNC_BYTE, 1'b1, 16'hABCD, 32'd1, 11'd8, 4'd15, 3'd0, 7'd0, 8'h00, 1'b1);
    drive(FUNC_BYTE, 1'b1, 16'hABCD, 32'd1, 11'd8, 4'd2, 3'd7, 7'd0, 8'h00, 1'b1);
    drive(FUNC_BYTE, 1'b1, 16'hABCD, 32'd1, 11'd2047, 4'd8, 3'd0, 7'd0, 8'h00, 1'b1);
    // A frame just before the sequence wraps, read out, then repeated as a duplicate.
    send_frame(16'hABCD, 32'hFFFF_FFFF, 8, 1, FRAME_GOOD);
    read_out(9);
    drive_packet(16'hABCD, 32'hFFFF_FFFF, 11'd8, 4'd1, 0, 8, 1'b1);
    // A frame left half done, if begun at all, ages out on the third tick after it opens.
    send_frame(16'hABCD, 32'd1, 10, 2, FRAME_ABANDON);
    repeat (3) drive_plain(FUNC_TICK);
    // Across the wrap with a gap of two frames, then a frame too short to check.
    send_frame(16'hABCD, 32'd2, 6, 1, FRAME_GOOD);
    send_frame(16'hABCD, 32'd3, 0, 1, FRAME_GOOD);

    write_timeout(32'd1);
    tick_pct = 1;
    random_traffic(500);

    write_timeout(32'hFFFF_FFFF);
    idle_pct = 58;
    tick_pct = 5;
    random_traffic(500);

    write_timeout(32'd1000);
    idle_pct = 0;
    random_traffic(500);

    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_fragment_reassembly_engine: PASS");
    end else begin
      $display("tb_fragment_reassembly_engine: FAIL");
    end
    $finish;
  end

endmodule
